>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop on every clock edge while out of reset.
`define RRTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rrts assertion failed");

// Require cons in the cycle after ante.
`define RRTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rrts assertion failed");

`endif

>>> design/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned BYTES_W     = 17;
	localparam logic [31:0] FRAME_BYTES = 32'd64;

	localparam logic [CFG_INDEX_W-1:0] REG_STACK_TOP   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STACK_BYTES = 2'd1;
	localparam logic [BYTES_W-1:0]     STACK_BYTES_RST = 17'd1024;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_DELAY,
		KIND_SWITCH,
		KIND_CREATE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] delay_ticks;
		logic [31:0] outgoing_sp;
	} item_t;

	typedef struct packed {
		logic [2:0]  running_task;
		logic [31:0] incoming_sp;
		logic        switch_request;
		logic [2:0]  created_slot;
		logic        create_full;
	} result_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

>>> design/round_robin_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_core
// Round-robin task scheduler with tick-based delay and slot creation.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_ready   item (item_t)
//   result    out        result_valid / result_ready  result (result_t)
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request is first captured and the stack offset product formed; then
// the slot tables are updated and the result register is loaded.
// A new request is taken while an earlier result waits; the update stalls
// until the result register is free. cfg_ready is always high.
// Reset is asynchronous and restores every slot table at once.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_core
	import rrts_pkg::*;
#(
	parameter int unsigned TASK_SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	cmd_t cmd;

	rrts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	rrts_dp #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> design/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Request sequencer: takes a request, fires the update once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rrts_ctrl
	import rrts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input  logic result_ready,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   valid_q, valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		valid_d    = valid_q && !result_ready;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!valid_q || result_ready) begin
					cmd.exec = 1'b1;
					valid_d  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = valid_q;

endmodule

>>> design/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: slot tables, tick counter, round-robin pick and
// result register.
// ----------------------------------------------------------------------------
module rrts_dp
	import rrts_pkg::*;
#(
	parameter int unsigned TASK_SLOTS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  item_t                  item,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int unsigned SW = $clog2(TASK_SLOTS);
	localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
	localparam int unsigned PW = CW + BYTES_W;

	logic [31:0]           top_q;
	logic [BYTES_W-1:0]    bytes_q;
	logic [TASK_SLOTS-1:0] ready_q;
	logic [31:0]           wake_q [TASK_SLOTS];
	logic [31:0]           sp_q   [TASK_SLOTS];
	logic [SW-1:0]         cur_q;
	logic [31:0]           tick_q;
	logic [CW-1:0]         used_q;
	item_t                 item_s1;
	logic [31:0]           prod_s1;
	result_t               res_q;

	logic [PW-1:0]         prod_w;
	logic [31:0]           tick_inc;
	logic [TASK_SLOTS-1:0] wake_hit;
	logic [SW-1:0]         pick;
	logic                  hit_hi;
	logic [SW-1:0]         pick_hi;
	logic                  hit_lo;
	logic [SW-1:0]         pick_lo;
	logic                  full;
	logic [SW-1:0]         id;
	logic                  sp_we;
	logic [SW-1:0]         sp_waddr;
	logic [31:0]           sp_wdata;
	logic [SW-1:0]         cur_new;
	result_t               res_d;

	assign cfg_ready = 1'b1;
	assign prod_w    = PW'(used_q) * PW'(bytes_q);
	assign tick_inc  = tick_q + 32'd1;
	assign full      = (used_q == CW'(TASK_SLOTS));
	assign id        = used_q[SW-1:0];

	always_comb begin
		wake_hit = '0;
		for (int i = 1; i < TASK_SLOTS; i++) begin
			wake_hit[i] = !ready_q[i] && (wake_q[i] == tick_inc);
		end
	end

	// Round-robin pick: lowest ready slot above the running one, else the
	// lowest ready non-idle slot up to and including it, else idle.
	always_comb begin
		hit_hi  = 1'b0;
		pick_hi = '0;
		hit_lo  = 1'b0;
		pick_lo = '0;
		for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
			if (ready_q[i] && (SW'(i) > cur_q)) begin
				hit_hi  = 1'b1;
				pick_hi = SW'(i);
			end
			if (ready_q[i] && (SW'(i) <= cur_q)) begin
				hit_lo  = 1'b1;
				pick_lo = SW'(i);
			end
		end
		if (hit_hi) begin
			pick = pick_hi;
		end else if (hit_lo) begin
			pick = pick_lo;
		end else begin
			pick = '0;
		end
	end

	always_comb begin
		sp_we    = 1'b0;
		sp_waddr = cur_q;
		sp_wdata = item_s1.outgoing_sp;
		cur_new  = cur_q;
		res_d    = '0;
		case (item_s1.kind)
			KIND_TICK: begin
				res_d.switch_request = 1'b1;
			end
			KIND_DELAY: begin
				res_d.switch_request = (cur_q != '0);
			end
			KIND_SWITCH: begin
				sp_we   = 1'b1;
				cur_new = pick;
			end
			KIND_CREATE: begin
				if (full) begin
					res_d.create_full = 1'b1;
				end else begin
					sp_we              = 1'b1;
					sp_waddr           = id;
					sp_wdata           = top_q - prod_s1 - FRAME_BYTES;
					res_d.created_slot = 3'(id);
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		res_d.running_task = 3'(cur_new);
		res_d.incoming_sp  = (sp_we && sp_waddr == cur_new) ? sp_wdata : sp_q[cur_new];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			bytes_q <= STACK_BYTES_RST;
			ready_q <= '1;
			cur_q   <= SW'(1);
			tick_q  <= '0;
			used_q  <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				wake_q[i] <= '0;
				sp_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STACK_TOP) begin
					top_q <= cfg_data;
				end else if (cfg_index == REG_STACK_BYTES) begin
					bytes_q <= cfg_data[BYTES_W-1:0];
				end
			end
			if (cmd.exec) begin
				if (sp_we) begin
					sp_q[sp_waddr] <= sp_wdata;
				end
				cur_q <= cur_new;
				case (item_s1.kind)
					KIND_TICK: begin
						tick_q  <= tick_inc;
						ready_q <= ready_q | wake_hit;
					end
					KIND_DELAY: begin
						if (cur_q != '0) begin
							wake_q[cur_q]  <= tick_q + item_s1.delay_ticks;
							ready_q[cur_q] <= 1'b0;
						end
					end
					KIND_CREATE: begin
						if (!full) begin
							ready_q[id] <= 1'b1;
							used_q      <= used_q + CW'(1);
						end
					end
					default: begin
						tick_q <= tick_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_s1 <= item;
			prod_s1 <= 32'(prod_w);
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

>>> design/rrts_checker.sv
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_checker
	import rrts_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	`RRTS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))
	`RRTS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, item_valid && item_ready, !item_ready)
	`RRTS_ASSERT_NEXT(a_result_follows, clk, arst_n, item_valid && item_ready && (!result_valid || result_ready), ##1 result_valid)
	`RRTS_ASSERT(a_full_no_slot, clk, arst_n, !(result_valid && result.create_full) || (result.created_slot == 3'd0))
	`RRTS_ASSERT(a_full_no_switch, clk, arst_n, !(result_valid && result.create_full && result.switch_request))

endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
